// ===== sv/mmpq_pkg.sv =====
`default_nettype none
package mmpq_pkg;

	localparam int unsigned COST_W = 32;

	typedef enum logic [1:0] {
		OP_ADD        = 2'd0,
		OP_SET_POLICY = 2'd1,
		OP_REMOVE     = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_SHIFT
	} cell_op_t;

	typedef struct packed {
		opcode_t            opcode;
		logic signed [31:0] cost;
		logic               take_largest;
	} cmd_word_t;

	typedef struct packed {
		logic signed [31:0] removed_cost;
		status_t            status;
	} rsp_word_t;

	typedef struct packed {
		cell_op_t           op;
		logic signed [31:0] cost;
	} cell_ctl_t;

endpackage
`default_nettype wire

// ===== sv/mmpq_cell.sv =====
`default_nettype none
module mmpq_cell (
	input  wire logic                                    clk,
	input  wire mmpq_pkg::cell_ctl_t                     ctl,
	input  wire logic                                    occupied,
	input  wire logic                                    is_last,
	input  wire logic                                    gt_prev,
	input  wire logic signed [mmpq_pkg::COST_W-1:0]      prev_value,
	input  wire logic signed [mmpq_pkg::COST_W-1:0]      next_value,
	output logic                                         gt,
	output logic signed [mmpq_pkg::COST_W-1:0]           value,
	output logic        [mmpq_pkg::COST_W-1:0]           tap
);

	logic signed [mmpq_pkg::COST_W-1:0] value_q;

	// empty cells count as greater so an insert lands at the tail
	assign gt    = !occupied || (value_q > ctl.cost);
	assign value = value_q;
	assign tap   = is_last ? value_q : '0;

	always_ff @(posedge clk) begin
		case (ctl.op)
			mmpq_pkg::CELL_INSERT: begin
				if (gt) begin
					value_q <= gt_prev ? prev_value : ctl.cost;
				end
			end
			mmpq_pkg::CELL_SHIFT: begin
				value_q <= next_value;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/min_max_removal_priority_queue_top.sv =====
// Bounded double-ended priority queue of signed 32-bit costs.
// Command channel cmd_valid/cmd_ready/cmd carries one word per command:
// add a cost, set the removal policy (smallest or largest first), or remove.
// Response channel rsp_valid/rsp_ready/rsp returns exactly one word per
// command: the removed cost (zero unless a remove succeeded) and a status
// (ok, remove on empty, add on full).
// Entries sit in a row of CAPACITY cells kept in ascending order; an add
// shifts the larger entries up one cell, a smallest-first remove shifts all
// entries down one cell, a largest-first remove only drops the tail.
// The response is registered and rsp_valid rises in the cycle after accept;
// one command per cycle is sustained while each response word is taken at
// once, limited by the single cell-row update per cycle. The response sits
// in an output register; a stalled receiver holds it and cmd_ready stays low
// until that word is taken, so nothing is lost. Reset empties the queue,
// selects smallest first and clears rsp_valid; no clearing pass is needed.
`default_nettype none
module min_max_removal_priority_queue_top #(
	parameter int unsigned CAPACITY = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cmd_valid,
	output logic                      cmd_ready,
	input  wire mmpq_pkg::cmd_word_t  cmd,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready,
	output mmpq_pkg::rsp_word_t       rsp
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic                                cmd_accept;
	logic [CW-1:0]                       count_q;
	logic [CW-1:0]                       count_m1;
	logic                                largest_first_q;
	logic                                full;
	logic                                empty;
	logic                                rsp_valid_q;
	mmpq_pkg::rsp_word_t                 rsp_q;
	mmpq_pkg::rsp_word_t                 rsp_next;
	mmpq_pkg::cell_ctl_t                 ctl;
	logic [CW-1:0]                       count_next;

	logic                                cell_gt    [CAPACITY];
	logic signed [mmpq_pkg::COST_W-1:0]  cell_value [CAPACITY];
	logic        [mmpq_pkg::COST_W-1:0]  cell_tap   [CAPACITY];
	logic        [mmpq_pkg::COST_W-1:0]  largest;

	assign cmd_ready  = !rsp_valid_q || rsp_ready;
	assign cmd_accept = cmd_valid && cmd_ready;
	assign full       = (count_q == CW'(CAPACITY));
	assign empty      = (count_q == '0);
	assign count_m1   = count_q - CW'(1);
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	// cell row
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                               gt_prev;
		logic signed [mmpq_pkg::COST_W-1:0] prev_value;
		logic signed [mmpq_pkg::COST_W-1:0] next_value;

		if (i == 0) begin : g_head
			assign gt_prev    = 1'b0;
			assign prev_value = ctl.cost;
		end else begin : g_body
			assign gt_prev    = cell_gt[i-1];
			assign prev_value = cell_value[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_value = cell_value[i];
		end else begin : g_inner
			assign next_value = cell_value[i+1];
		end

		mmpq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occupied   (CW'(i) < count_q),
			.is_last    (CW'(i) == count_m1),
			.gt_prev    (gt_prev),
			.prev_value (prev_value),
			.next_value (next_value),
			.gt         (cell_gt[i]),
			.value      (cell_value[i]),
			.tap        (cell_tap[i])
		);
	end

	// tail entry: only the last occupied cell drives its tap
	always_comb begin
		largest = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			largest = largest | cell_tap[i];
		end
	end

	always_comb begin
		ctl.op                = mmpq_pkg::CELL_HOLD;
		ctl.cost              = cmd.cost;
		count_next            = count_q;
		rsp_next.removed_cost = '0;
		rsp_next.status       = mmpq_pkg::ST_OK;
		case (cmd.opcode)
			mmpq_pkg::OP_ADD: begin
				if (full) begin
					rsp_next.status = mmpq_pkg::ST_FULL;
				end else begin
					ctl.op     = cmd_accept ? mmpq_pkg::CELL_INSERT : mmpq_pkg::CELL_HOLD;
					count_next = count_q + CW'(1);
				end
			end
			mmpq_pkg::OP_REMOVE: begin
				if (empty) begin
					rsp_next.status = mmpq_pkg::ST_EMPTY;
				end else begin
					count_next = count_m1;
					if (largest_first_q) begin
						rsp_next.removed_cost = largest;
					end else begin
						rsp_next.removed_cost = cell_value[0];
						ctl.op = cmd_accept ? mmpq_pkg::CELL_SHIFT : mmpq_pkg::CELL_HOLD;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q         <= '0;
			largest_first_q <= 1'b0;
			rsp_valid_q     <= 1'b0;
		end else begin
			if (cmd_accept) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
				if (cmd.opcode == mmpq_pkg::OP_SET_POLICY) begin
					largest_first_q <= cmd.take_largest;
				end
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_accept) begin
			rsp_q <= rsp_next;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_full_add: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_accept && cmd.opcode == mmpq_pkg::OP_ADD && full
		|=> rsp_q.status == mmpq_pkg::ST_FULL && $stable(count_q))
		else $error("add on full queue changed state or wrong status");

	a_empty_remove: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_accept && cmd.opcode == mmpq_pkg::OP_REMOVE && empty
		|=> rsp_q.status == mmpq_pkg::ST_EMPTY && rsp_q.removed_cost == '0)
		else $error("remove on empty queue gave wrong word");

	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_accept && cmd.opcode == mmpq_pkg::OP_REMOVE && !empty
		|=> count_q == $past(count_q) - CW'(1))
		else $error("remove did not drop one entry");

	a_sorted_head: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CW'(2) |-> cell_value[0] <= cell_value[1])
		else $error("cell row out of order");

endmodule
`default_nettype wire
